[rtl/core/json_string_unescape_utf8_macros.svh]
// Assertion helpers for the JSON string unescaper.
// Included by the top level; needs nothing else.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// same-cycle implication, off while in reset
`define JSU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while in reset
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/jsu_pkg.sv]
// Shared types, codes and helper functions of the JSON string unescaper.
// Used by jsu_dec, jsu_ser and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // most words one input byte can cause (four UTF-8 bytes plus an error)
  localparam int MaxRes = 5;
  localparam int CntW   = 3;

  // scan modes
  typedef enum logic [2:0] {
    MODE_PLAIN   = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_HEX     = 3'd2,
    MODE_WANT_BS = 3'd3,
    MODE_WANT_U  = 3'd4
  } jsu_mode_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } jsu_kind_t;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_UNTERM_STR  = 4'd1,
    ERR_CTRL        = 4'd2,
    ERR_UNTERM_ESC  = 4'd3,
    ERR_UNKNOWN_ESC = 4'd4,
    ERR_TRUNC_HEX   = 4'd5,
    ERR_BAD_HEX     = 4'd6,
    ERR_LONE_HIGH   = 4'd7,
    ERR_LONE_LOW    = 4'd8
  } jsu_err_t;

  // characters of interest
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // surrogate halves, by the top six bits of the code unit
  localparam logic [5:0] SUR_HIGH_TAG = 6'b110110;
  localparam logic [5:0] SUR_LOW_TAG  = 6'b110111;
  localparam logic [20:0] SUPP_BASE   = 21'h1_0000;

  // one result word
  typedef struct packed {
    logic [7:0] data;
    jsu_kind_t  kind;
    jsu_err_t   code;
  } jsu_res_t;

  // all words caused by one input byte, ent[0] goes out first
  typedef struct packed {
    logic [CntW-1:0]          cnt;
    jsu_res_t [MaxRes-1:0]    ent;
  } jsu_bundle_t;

  // UTF-8 encoding of one code point, b[0] first
  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } jsu_utf8_t;

  // hex digit value; bit 4 set when the byte is not a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    begin
      hex_digit = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
        t = c - 8'h30;
        hex_digit = {1'b0, t[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
        t = c - 8'h57;
        hex_digit = {1'b0, t[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
        t = c - 8'h37;
        hex_digit = {1'b0, t[3:0]};
      end
    end
  endfunction

  function automatic jsu_utf8_t utf8_enc(input logic [20:0] cp);
    jsu_utf8_t r;
    begin
      r = '0;
      if (cp[20:7] == '0) begin
        r.n    = 3'd1;
        r.b[0] = cp[7:0];
      end else if (cp[20:11] == '0) begin
        r.n    = 3'd2;
        r.b[0] = {3'b110, cp[10:6]};
        r.b[1] = {2'b10, cp[5:0]};
      end else if (cp[20:16] == '0) begin
        r.n    = 3'd3;
        r.b[0] = {4'b1110, cp[15:12]};
        r.b[1] = {2'b10, cp[11:6]};
        r.b[2] = {2'b10, cp[5:0]};
      end else begin
        r.n    = 3'd4;
        r.b[0] = {5'b11110, cp[20:18]};
        r.b[1] = {2'b10, cp[17:12]};
        r.b[2] = {2'b10, cp[11:6]};
        r.b[3] = {2'b10, cp[5:0]};
      end
      utf8_enc = r;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/core/jsu_dec.sv]
// Scan state and decode logic: turns one input byte into a bundle of words.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_dec (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take,
  input  wire logic [7:0]          data_byte,
  input  wire logic                text_ends,
  output jsu_pkg::jsu_bundle_t     bundle
);
  import jsu_pkg::*;

  jsu_mode_t   mode_r, mode_nxt;
  logic [1:0]  hpos_r, hpos_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [9:0]  hb_r, hb_nxt;
  logic        second_r, second_nxt;
  logic        bad_r, bad_nxt;

  logic [CntW-1:0] ndata;
  logic [3:0][7:0] dbytes;
  logic            has_term;
  jsu_kind_t       term_kind;
  jsu_err_t        term_code;
  logic [4:0]      hd;
  logic [15:0]     acc_sh;
  logic            bad_sh;
  logic [20:0]     cp;
  logic            use_enc;
  jsu_utf8_t       enc;
  logic            esc_ok;
  logic [7:0]      esc_val;

  // next state and the words this byte causes
  always_comb begin
    mode_nxt   = MODE_PLAIN;
    hpos_nxt   = '0;
    acc_nxt    = '0;
    hb_nxt     = '0;
    second_nxt = 1'b0;
    bad_nxt    = 1'b0;
    ndata      = '0;
    dbytes     = '0;
    has_term   = 1'b0;
    term_kind  = KIND_ERROR;
    term_code  = ERR_NONE;
    cp         = '0;
    use_enc    = 1'b0;
    esc_ok     = 1'b1;
    esc_val    = data_byte;

    hd     = hex_digit(data_byte);
    bad_sh = bad_r | hd[4];
    acc_sh = {acc_r[11:0], (hd[4] ? 4'h0 : hd[3:0])};

    unique case (data_byte)
      CH_QUOTE, CH_BSLASH, CH_SLASH: esc_val = data_byte;
      CH_B:    esc_val = 8'h08;
      CH_F:    esc_val = 8'h0C;
      CH_N:    esc_val = 8'h0A;
      CH_R:    esc_val = 8'h0D;
      CH_T:    esc_val = 8'h09;
      default: esc_ok  = 1'b0;
    endcase

    unique case (mode_r)
      MODE_ESC: begin
        if (esc_ok) begin
          ndata     = CntW'(1);
          dbytes[0] = esc_val;
          has_term  = text_ends;
          term_code = ERR_UNTERM_STR;
        end else if (data_byte == CH_U) begin
          if (text_ends) begin
            has_term  = 1'b1;
            term_code = ERR_TRUNC_HEX;
          end else begin
            mode_nxt = MODE_HEX;
          end
        end else begin
          has_term  = 1'b1;
          term_code = ERR_UNKNOWN_ESC;
        end
      end

      MODE_HEX: begin
        if (hpos_r != 2'd3) begin
          // digits one to three: collect, or stop on end of text
          if (text_ends) begin
            has_term  = 1'b1;
            term_code = ERR_TRUNC_HEX;
          end else begin
            mode_nxt   = MODE_HEX;
            hpos_nxt   = hpos_r + 2'd1;
            acc_nxt    = acc_sh;
            bad_nxt    = bad_sh;
            hb_nxt     = hb_r;
            second_nxt = second_r;
          end
        end else if (bad_sh) begin
          has_term  = 1'b1;
          term_code = ERR_BAD_HEX;
        end else if (!second_r) begin
          // first code unit
          if (acc_sh[15:10] == SUR_HIGH_TAG) begin
            if (text_ends) begin
              has_term  = 1'b1;
              term_code = ERR_LONE_HIGH;
            end else begin
              mode_nxt = MODE_WANT_BS;
              hb_nxt   = acc_sh[9:0];
            end
          end else if (acc_sh[15:10] == SUR_LOW_TAG) begin
            has_term  = 1'b1;
            term_code = ERR_LONE_LOW;
          end else begin
            cp        = {5'd0, acc_sh};
            use_enc   = 1'b1;
            has_term  = text_ends;
            term_code = ERR_UNTERM_STR;
          end
        end else begin
          // second code unit of a pair
          if (acc_sh[15:10] == SUR_LOW_TAG) begin
            cp        = 21'({hb_r, acc_sh[9:0]}) + SUPP_BASE;
            use_enc   = 1'b1;
            has_term  = text_ends;
            term_code = ERR_UNTERM_STR;
          end else begin
            has_term  = 1'b1;
            term_code = ERR_LONE_HIGH;
          end
        end
      end

      MODE_WANT_BS: begin
        if (data_byte != CH_BSLASH || text_ends) begin
          has_term  = 1'b1;
          term_code = ERR_LONE_HIGH;
        end else begin
          mode_nxt = MODE_WANT_U;
          hb_nxt   = hb_r;
        end
      end

      MODE_WANT_U: begin
        if (data_byte != CH_U) begin
          has_term  = 1'b1;
          term_code = ERR_LONE_HIGH;
        end else if (text_ends) begin
          has_term  = 1'b1;
          term_code = ERR_TRUNC_HEX;
        end else begin
          mode_nxt   = MODE_HEX;
          hb_nxt     = hb_r;
          second_nxt = 1'b1;
        end
      end

      default: begin
        // plain text
        if (data_byte == CH_QUOTE) begin
          has_term  = 1'b1;
          term_kind = KIND_CLOSE;
        end else if (data_byte < CH_SPACE) begin
          has_term  = 1'b1;
          term_code = ERR_CTRL;
        end else if (data_byte == CH_BSLASH) begin
          if (text_ends) begin
            has_term  = 1'b1;
            term_code = ERR_UNTERM_ESC;
          end else begin
            mode_nxt = MODE_ESC;
          end
        end else begin
          ndata     = CntW'(1);
          dbytes[0] = data_byte;
          has_term  = text_ends;
          term_code = ERR_UNTERM_STR;
        end
      end
    endcase

    enc = utf8_enc(cp);
    if (use_enc) begin
      ndata  = enc.n;
      dbytes = enc.b;
    end
  end

  // pack data bytes first, then the close or error word
  always_comb begin
    bundle     = '0;
    bundle.cnt = ndata + CntW'(has_term);
    for (int i = 0; i < 4; i++) begin
      if (CntW'(i) < ndata) begin
        bundle.ent[i] = '{data: dbytes[i], kind: KIND_DATA, code: ERR_NONE};
      end
    end
    if (has_term) begin
      bundle.ent[ndata] = '{data: 8'h00, kind: term_kind, code: term_code};
    end
  end

  // scan state advances on every accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_PLAIN;
      hpos_r   <= '0;
      acc_r    <= '0;
      hb_r     <= '0;
      second_r <= 1'b0;
      bad_r    <= 1'b0;
    end else if (take) begin
      mode_r   <= mode_nxt;
      hpos_r   <= hpos_nxt;
      acc_r    <= acc_nxt;
      hb_r     <= hb_nxt;
      second_r <= second_nxt;
      bad_r    <= bad_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/jsu_ser.sv]
// Result buffer: holds one byte's bundle of words and shifts them out.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_ser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire jsu_pkg::jsu_bundle_t bundle,
  output logic                      can_take,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output jsu_pkg::jsu_res_t         head,
  output logic                      head_last
);
  import jsu_pkg::*;

  logic [CntW-1:0]        cnt_r, cnt_nxt;
  jsu_res_t [MaxRes-1:0]  ent_r, ent_nxt;
  logic                   pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid & out_ready;
  assign head      = ent_r[0];
  assign head_last = (cnt_r == CntW'(1));
  // free now, or the last word leaves this cycle
  assign can_take  = (cnt_r == '0) || (head_last && out_ready);

  // load a new bundle, else shift one word out
  always_comb begin
    cnt_nxt = cnt_r;
    ent_nxt = ent_r;
    if (load) begin
      cnt_nxt = bundle.cnt;
      ent_nxt = bundle.ent;
    end else if (pop) begin
      cnt_nxt = cnt_r - CntW'(1);
      for (int i = 0; i < MaxRes - 1; i++) begin
        ent_nxt[i] = ent_r[i+1];
      end
      ent_nxt[MaxRes-1] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

`default_nettype wire

[rtl/core/json_string_unescape_utf8.sv]
// Top level of the JSON string body unescaper (bytes in, UTF-8 words out).
// Depends on jsu_pkg, jsu_dec, jsu_ser and json_string_unescape_utf8_macros.svh.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_data_byte, in_text_ends
//   out     | output    | out_valid / out_ready| out_out_byte, out_kind,
//           |           |                      | out_error_code, out_last_of_run
//
// One input byte is taken per cycle while each byte gives at most one word
// and out_ready stays high. A byte that gives n words (up to five: a 4-byte
// UTF-8 sequence plus an error) holds the input while the result buffer drains.
// A byte's first word appears in the cycle after the byte is taken.
// Synchronous active-low reset returns to plain text and empties the buffer.
// out_ready low stalls the buffer, and the input once its last word waits.
`timescale 1ns / 1ps
`default_nettype none
`include "json_string_unescape_utf8_macros.svh"

module json_string_unescape_utf8 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_text_ends,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_out_byte,
  output logic [1:0]       out_kind,
  output logic [3:0]       out_error_code,
  output logic             out_last_of_run
);
  import jsu_pkg::*;

  logic        take;
  logic        load;
  jsu_bundle_t bundle;
  jsu_res_t    head;

  assign take = in_valid & in_ready;
  assign load = take & (bundle.cnt != '0);

  jsu_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .text_ends (in_text_ends),
    .bundle    (bundle)
  );

  jsu_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .bundle    (bundle),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head),
    .head_last (out_last_of_run)
  );

  assign out_out_byte   = head.data;
  assign out_kind       = head.kind;
  assign out_error_code = head.code;

  // a close or an error always ends the run of its byte
  `JSU_ASSERT_SAME(a_term_last, clk, rst_n, out_valid && (out_kind != KIND_DATA), out_last_of_run, "close or error word not last of its run")
  // data words carry no error code
  `JSU_ASSERT_SAME(a_data_no_err, clk, rst_n, out_valid && (out_kind == KIND_DATA), out_error_code == ERR_NONE, "data word with error code")
  // a byte that causes words shows one on the next cycle
  `JSU_ASSERT_NEXT(a_load_shows, clk, rst_n, load, out_valid, "loaded bundle not presented")

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for json_string_unescape_utf8: random JSON string bytes in, UTF-8 words out.
// Depends on jsu_pkg and the top level only; an in-bench predictor supplies the expected words.
`timescale 1ns / 1ps

module tb;
  import jsu_pkg::*;

  localparam int IdleMax     = 13;
  localparam int RandomBytes = 380;
  localparam int QuietLimit  = 1000;
  localparam int DrainCycles = 20;

  // hex digit characters
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;

  // surrogate ranges of a UTF-16 code unit
  localparam logic [15:0] SurHighLo = 16'hD800;
  localparam logic [15:0] SurHighHi = 16'hDBFF;
  localparam logic [15:0] SurLowLo  = 16'hDC00;
  localparam logic [15:0] SurLowHi  = 16'hDFFF;

  typedef struct packed {
    logic [7:0] data;
    jsu_kind_t  kind;
    jsu_err_t   code;
    logic       last;
  } word_t;

  // Decoder predictor plus the FIFO of words still owed by the block
  class unescape_scoreboard;
    jsu_mode_t   mode;
    logic [1:0]  hex_pos;
    logic [15:0] unit_acc;
    logic [9:0]  high_bits;
    bit          second_half;
    bit          bad_digit;
    word_t       owed[$];
    int          errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      mode        = MODE_PLAIN;
      hex_pos     = '0;
      unit_acc    = '0;
      high_bits   = '0;
      second_half = 1'b0;
      bad_digit   = 1'b0;
    endfunction

    function void push(jsu_kind_t k, jsu_err_t c, logic [7:0] d);
      word_t w;
      w.data = d;
      w.kind = k;
      w.code = c;
      w.last = 1'b0;
      owed.insert(owed.size(), w);
    endfunction

    function void push_error(jsu_err_t c);
      clear_state();
      push(KIND_ERROR, c, 8'h00);
    endfunction

    function void push_data(logic [7:0] d, bit ends);
      push(KIND_DATA, ERR_NONE, d);
      if (ends) push_error(ERR_UNTERM_STR);
    endfunction

    // code point to one..four UTF-8 bytes
    function void push_utf8(logic [20:0] cp, bit ends);
      if (cp <= 21'h7F) begin
        push(KIND_DATA, ERR_NONE, cp[7:0]);
      end else if (cp <= 21'h7FF) begin
        push(KIND_DATA, ERR_NONE, {3'b110, cp[10:6]});
        push(KIND_DATA, ERR_NONE, {2'b10, cp[5:0]});
      end else if (cp <= 21'hFFFF) begin
        push(KIND_DATA, ERR_NONE, {4'b1110, cp[15:12]});
        push(KIND_DATA, ERR_NONE, {2'b10, cp[11:6]});
        push(KIND_DATA, ERR_NONE, {2'b10, cp[5:0]});
      end else begin
        push(KIND_DATA, ERR_NONE, {5'b11110, cp[20:18]});
        push(KIND_DATA, ERR_NONE, {2'b10, cp[17:12]});
        push(KIND_DATA, ERR_NONE, {2'b10, cp[11:6]});
        push(KIND_DATA, ERR_NONE, {2'b10, cp[5:0]});
      end
      if (ends) push_error(ERR_UNTERM_STR);
    endfunction

    // bit 4 flags a non-hex byte
    function logic [4:0] digit_of(logic [7:0] b);
      if (b >= CH_ZERO && b <= CH_NINE) return {1'b0, b[3:0]};
      if ((b >= CH_LOWER_A && b <= CH_LOWER_F) || (b >= CH_UPPER_A && b <= CH_UPPER_F))
        return {1'b0, b[3:0] + 4'd9};
      return 5'h10;
    endfunction

    function void hex_byte(logic [7:0] b, bit ends);
      logic [4:0]  d;
      logic [15:0] v;
      logic [15:0] diff;
      logic [20:0] cp;
      d = digit_of(b);
      if (d[4]) begin
        bad_digit = 1'b1;
        d = '0;
      end
      unit_acc = {unit_acc[11:0], d[3:0]};
      v = unit_acc;
      if (hex_pos != 2'd3) begin
        // truncation beats a bad digit
        if (ends) push_error(ERR_TRUNC_HEX);
        else hex_pos = hex_pos + 2'd1;
      end else if (bad_digit) begin
        push_error(ERR_BAD_HEX);
      end else if (!second_half) begin
        if (v >= SurHighLo && v <= SurHighHi) begin
          if (ends) begin
            push_error(ERR_LONE_HIGH);
          end else begin
            diff = v - SurHighLo;
            clear_state();
            high_bits = diff[9:0];
            mode = MODE_WANT_BS;
          end
        end else if (v >= SurLowLo && v <= SurLowHi) begin
          push_error(ERR_LONE_LOW);
        end else begin
          clear_state();
          push_utf8({5'd0, v}, ends);
        end
      end else if (v >= SurLowLo && v <= SurLowHi) begin
        cp = SUPP_BASE + {high_bits, 10'd0} + (v - SurLowLo);
        clear_state();
        push_utf8(cp, ends);
      end else begin
        push_error(ERR_LONE_HIGH);
      end
    endfunction

    // predict all words caused by one accepted input byte
    function void note_input(logic [7:0] b, bit ends);
      int first;
      first = owed.size();
      case (mode)
        MODE_ESC: begin
          mode = MODE_PLAIN;
          case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: push_data(b, ends);
            CH_B: push_data(8'h08, ends);
            CH_F: push_data(8'h0C, ends);
            CH_N: push_data(8'h0A, ends);
            CH_R: push_data(8'h0D, ends);
            CH_T: push_data(8'h09, ends);
            CH_U: begin
              if (ends) begin
                push_error(ERR_TRUNC_HEX);
              end else begin
                clear_state();
                mode = MODE_HEX;
              end
            end
            default: push_error(ERR_UNKNOWN_ESC);
          endcase
        end
        MODE_HEX: hex_byte(b, ends);
        MODE_WANT_BS: begin
          if (b != CH_BSLASH || ends) push_error(ERR_LONE_HIGH);
          else mode = MODE_WANT_U;
        end
        MODE_WANT_U: begin
          if (b != CH_U) begin
            push_error(ERR_LONE_HIGH);
          end else if (ends) begin
            push_error(ERR_TRUNC_HEX);
          end else begin
            mode        = MODE_HEX;
            hex_pos     = '0;
            unit_acc    = '0;
            bad_digit   = 1'b0;
            second_half = 1'b1;
          end
        end
        default: begin
          clear_state();
          if (b == CH_QUOTE) begin
            push(KIND_CLOSE, ERR_NONE, 8'h00);
          end else if (b < CH_SPACE) begin
            push_error(ERR_CTRL);
          end else if (b == CH_BSLASH) begin
            if (ends) push_error(ERR_UNTERM_ESC);
            else mode = MODE_ESC;
          end else begin
            push_data(b, ends);
          end
        end
      endcase
      if (owed.size() > first) owed[owed.size() - 1].last = 1'b1;
    endfunction

    task report_mismatch(string what);
      $display("ERROR at %0t: %s", $time, what);
      errors++;
    endtask

    task check_word(logic [7:0] d, logic [1:0] k, logic [3:0] c, logic l);
      word_t w;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("word with nothing owed: byte %02h kind %0d code %0d",
                                  d, k, c));
      end else begin
        w = owed.pop_front();
        if (d !== w.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", d, w.data));
        if (k !== w.kind)
          report_mismatch($sformatf("kind %0d, want %0d", k, w.kind));
        if (c !== w.code)
          report_mismatch($sformatf("error_code %0d, want %0d", c, w.code));
        if (l !== w.last)
          report_mismatch($sformatf("last_of_run %0b, want %0b", l, w.last));
      end
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_data_byte;
  logic       in_text_ends;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_out_byte;
  logic [1:0] out_kind;
  logic [3:0] out_error_code;
  logic       out_last_of_run;

  unescape_scoreboard sb = new();
  bit    idle_in   = 1'b1;
  bit    idle_out  = 1'b1;
  int    bytes_sent = 0;
  int    quiet      = 0;
  string esc_letters = "\"\\/bfnrt";

  json_string_unescape_utf8 dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_text_ends    (in_text_ends),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_out_byte    (out_out_byte),
    .out_kind        (out_kind),
    .out_error_code  (out_error_code),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // drive one byte; returns at the falling edge after it is taken
  task automatic send(logic [7:0] b, bit ends);
    int gap;
    gap = idle_in ? $urandom_range(0, IdleMax) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_text_ends <= ends;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b, ends);
    bytes_sent++;
    @(negedge clk);
  endtask

  // the text occasionally ends anywhere
  task automatic send_rnd_end(logic [7:0] b);
    send(b, $urandom_range(0, 39) == 0);
  endtask

  task automatic send_text(string s, bit end_last);
    for (int i = 0; i < s.len(); i++) send(s[i], end_last && i == s.len() - 1);
  endtask

  // \uXXXX with mixed-case digits, now and then a bad digit
  task automatic send_unit(logic [15:0] v);
    logic [3:0] nib;
    logic [7:0] c;
    send_rnd_end(CH_BSLASH);
    send_rnd_end(CH_U);
    for (int i = 3; i >= 0; i--) begin
      nib = v[i*4 +: 4];
      if (nib < 4'd10) c = CH_ZERO + nib;
      else c = ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + nib - 8'd10;
      if ($urandom_range(0, 29) == 0) c = 8'($urandom_range(0, 255));
      send_rnd_end(c);
    end
  endtask

  function automatic logic [15:0] any_unit();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(16'h0000, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
      3:       return 16'($urandom_range(16'hE000, 16'hFFFF));
      4:       return 16'($urandom_range(SurLowLo, SurLowHi));
      default: return 16'($urandom_range(SurHighLo, SurHighHi));
    endcase
  endfunction

  // one random piece of string body, mostly well formed
  task automatic send_segment();
    int n;
    if ($urandom_range(0, 29) == 0) idle_in = !idle_in;
    case ($urandom_range(0, 11))
      0, 1, 2: begin
        n = $urandom_range(1, 6);
        repeat (n) send_rnd_end(8'($urandom_range(CH_SPACE, 255)));
      end
      3: send_rnd_end(CH_QUOTE);
      4: send_rnd_end(8'($urandom_range(0, CH_SPACE - 1)));
      5: begin
        send_rnd_end(CH_BSLASH);
        send_rnd_end(esc_letters[$urandom_range(0, 7)]);
      end
      6: begin
        send_rnd_end(CH_BSLASH);
        send_rnd_end(8'($urandom_range(0, 255)));
      end
      7, 8: send_unit(any_unit());
      9, 10: begin
        send_unit(16'($urandom_range(SurHighLo, SurHighHi)));
        send_unit($urandom_range(0, 5) == 0 ? any_unit()
                                           : 16'($urandom_range(SurLowLo, SurLowHi)));
      end
      default: begin
        // high half followed by a random byte, sometimes after a backslash
        send_unit(16'($urandom_range(SurHighLo, SurHighHi)));
        if ($urandom_range(0, 1)) send_rnd_end(CH_BSLASH);
        send_rnd_end(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // stimulus
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = 8'h00;
    in_text_ends = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: close, control, top byte with end of text, escapes, a pair
    send(CH_QUOTE, 1'b0);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b1);
    send(CH_BSLASH, 1'b1);
    send_text("\\x", 1'b0);
    send_text("\\u", 1'b1);
    send_text("\\uD83D\\uDE00", 1'b0);
    send_text("\\uDBFFx", 1'b0);

    bytes_sent = 0;
    while (bytes_sent < RandomBytes) send_segment();
    in_valid <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // receiver: random stall before each word, sometimes none at all
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) idle_out = !idle_out;
      stall = idle_out ? $urandom_range(0, IdleMax) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_word(out_out_byte, out_kind, out_error_code, out_last_of_run);
      @(negedge clk);
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet == QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
